>>> hw/rtl/bidfl_pkg.sv
// Shared types, widths and codes for the block-id free list.
package bidfl_pkg;

  localparam int ID_W        = 10;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int USE_W       = 11;
  localparam int MAX_IDS_DEF = 1024;

  // request opcodes; the fourth code has no meaning and is rejected
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_TAKEN = 2'd1,
    ST_RANGE = 2'd2
  } bidfl_st_t;

  // what the final cycle of a transaction applies to the counters
  typedef enum logic [2:0] {
    CM_POP,
    CM_MARK,
    CM_REL,
    CM_FILL,
    CM_SRCH,
    CM_FAIL,
    CM_EXH
  } bidfl_cm_t;

  typedef struct packed {
    logic      latch;
    logic      rd_top;
    logic      rd_ptr;
    logic      rd_ptr1;
    logic      wr_fill;
    logic      wr_shift;
    logic      ptr_mark;
    logic      ptr_zero;
    logic      ptr_inc;
    logic      out_load;
    bidfl_cm_t commit;
    bidfl_st_t status;
  } bidfl_cmd_t;

  typedef struct packed {
    logic fc_zero;
    logic mark_full;
    logic fc_full;
    logic used_zero;
    logic id_oor;
    logic id_ge_mark;
    logic gap_ovf;
    logic fill_done;
    logic match;
    logic srch_last;
    logic out_free;
  } bidfl_stat_t;

endpackage

>>> hw/rtl/bidfl_if.sv
// Request and response channel interfaces of the block-id free list.
interface bidfl_req_if import bidfl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [ID_W-1:0] block_id;

  modport source (output valid, output operation, output block_id, input ready);
  modport sink   (input valid, input operation, input block_id, output ready);
endinterface

interface bidfl_rsp_if import bidfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  result_id;
  logic [ST_W-1:0]  status;
  logic [USE_W-1:0] in_use_count;

  modport source (output valid, output result_id, output status, output in_use_count,
                  input ready);
  modport sink   (input valid, input result_id, input status, input in_use_count,
                  output ready);
endinterface

>>> hw/rtl/bidfl_dp.sv
// Datapath: free stack memory, counters, search pointer and result register.
module bidfl_dp import bidfl_pkg::*; #(
  parameter int MAX_IDS = MAX_IDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ID_W-1:0]   in_block_id,
  input  bidfl_cmd_t        cmd,
  input  logic              out_ready,
  output bidfl_stat_t       stat,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_result_id,
  output logic [ST_W-1:0]   out_status,
  output logic [USE_W-1:0]  out_in_use_count
);

  localparam int AW = $clog2(MAX_IDS);
  localparam int CW = $clog2(MAX_IDS + 1);
  localparam int WW = ((CW > ID_W) ? CW : ID_W) + 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_IDS);
  localparam logic [WW-1:0] MAX_W = WW'(MAX_IDS);

  logic [ID_W-1:0] mem [MAX_IDS];
  logic [ID_W-1:0] rd_data_r;

  logic [CW-1:0] fc_r, fc_nxt;
  logic [CW-1:0] mark_r, mark_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ID_W-1:0] res_id_r, res_id_nxt;
  logic [ST_W-1:0] res_st_r, res_st_nxt;
  logic [USE_W-1:0] res_use_r, res_use_nxt;

  logic [CW-1:0]   fc_m1, ptr_p1;
  logic            rd_en, wr_en, commit_rel;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [ID_W-1:0] wr_data;

  assign fc_m1  = fc_r - 1'b1;
  assign ptr_p1 = ptr_r + 1'b1;

  // single read port, single write port
  assign commit_rel = cmd.out_load && (cmd.commit == CM_REL);
  assign rd_en      = cmd.rd_top | cmd.rd_ptr | cmd.rd_ptr1;
  assign wr_en      = cmd.wr_fill | cmd.wr_shift | commit_rel;

  always_comb begin
    if (cmd.rd_top) begin
      rd_addr = fc_m1[AW-1:0];
    end else if (cmd.rd_ptr1) begin
      rd_addr = ptr_p1[AW-1:0];
    end else begin
      rd_addr = ptr_r[AW-1:0];
    end
    wr_addr = cmd.wr_shift ? ptr_r[AW-1:0] : fc_r[AW-1:0];
    if (cmd.wr_fill) begin
      wr_data = ID_W'(ptr_r);
    end else if (cmd.wr_shift) begin
      wr_data = rd_data_r;
    end else begin
      wr_data = id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    fc_nxt        = fc_r;
    mark_nxt      = mark_r;
    used_nxt      = used_r;
    ptr_nxt       = ptr_r;
    id_nxt        = id_r;
    res_id_nxt    = res_id_r;
    res_st_nxt    = res_st_r;
    res_use_nxt   = res_use_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.latch) begin
      id_nxt = in_block_id;
    end
    if (cmd.ptr_mark) begin
      ptr_nxt = mark_r;
    end else if (cmd.ptr_zero) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc || cmd.wr_fill || cmd.wr_shift) begin
      ptr_nxt = ptr_p1;
    end
    if (cmd.wr_fill) begin
      fc_nxt = fc_r + 1'b1;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      res_st_nxt    = cmd.status;
      res_id_nxt    = id_r;
      case (cmd.commit)
        CM_POP: begin
          fc_nxt     = fc_m1;
          used_nxt   = used_r + 1'b1;
          res_id_nxt = rd_data_r;
        end
        CM_MARK: begin
          mark_nxt   = mark_r + 1'b1;
          used_nxt   = used_r + 1'b1;
          res_id_nxt = ID_W'(mark_r);
        end
        CM_REL: begin
          fc_nxt   = fc_r + 1'b1;
          used_nxt = used_r - 1'b1;
        end
        CM_FILL: begin
          mark_nxt = CW'(id_r) + 1'b1;
          used_nxt = used_r + 1'b1;
        end
        CM_SRCH: begin
          fc_nxt   = fc_m1;
          used_nxt = used_r + 1'b1;
        end
        CM_EXH: begin
          res_id_nxt = '0;
        end
        default: begin
        end
      endcase
      res_use_nxt = USE_W'(used_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      mark_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fc_r        <= fc_nxt;
      mark_r      <= mark_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    id_r      <= id_nxt;
    res_id_r  <= res_id_nxt;
    res_st_r  <= res_st_nxt;
    res_use_r <= res_use_nxt;
  end

  always_comb begin
    stat.fc_zero    = (fc_r == '0);
    stat.mark_full  = (mark_r >= MAX_C);
    stat.fc_full    = (fc_r >= MAX_C);
    stat.used_zero  = (used_r == '0);
    stat.id_oor     = (WW'(in_block_id) >= MAX_W);
    stat.id_ge_mark = (WW'(in_block_id) >= WW'(mark_r));
    stat.gap_ovf    = ((WW'(fc_r) + WW'(in_block_id) - WW'(mark_r)) > MAX_W);
    stat.fill_done  = (WW'(ptr_r) == WW'(id_r));
    stat.match      = (rd_data_r == id_r);
    stat.srch_last  = (ptr_p1 == fc_r);
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_result_id    = res_id_r;
  assign out_status       = res_st_r;
  assign out_in_use_count = res_use_r;

`ifndef SYNTHESIS
  // skipped-id pushes bump the free count ahead of the mark, so check after each commit
  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (((CW+1)'(fc_r) + (CW+1)'(used_r)) == (CW+1)'(mark_r)))
    else $error("free count plus used count differs from high-water mark");

  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= MAX_C)
    else $error("high-water mark beyond id space");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("free stack read and write in the same cycle");
`endif

endmodule

>>> hw/rtl/bidfl_ctrl.sv
// Controller: decodes each request and sequences stack pushes, search and compaction.
module bidfl_ctrl import bidfl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  input  bidfl_stat_t     stat,
  output logic            in_ready,
  output bidfl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DONE   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_SR_RD  = 3'd3;
  localparam logic [2:0] S_SR_CMP = 3'd4;
  localparam logic [2:0] S_SH_RD  = 3'd5;
  localparam logic [2:0] S_SH_WR  = 3'd6;

  logic [2:0] state_r, state_nxt;
  bidfl_cm_t  cm_r, cm_nxt;
  bidfl_st_t  st_r, st_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cm_nxt    = cm_r;
    st_nxt    = st_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DONE;
          st_nxt    = ST_OK;
          cm_nxt    = CM_FAIL;
          unique case (in_op)
            OP_ALLOC: begin
              if (!stat.fc_zero) begin
                cmd.rd_top = 1'b1;
                cm_nxt     = CM_POP;
              end else if (!stat.mark_full) begin
                cm_nxt = CM_MARK;
              end else begin
                cm_nxt = CM_EXH;
                st_nxt = ST_RANGE;
              end
            end
            OP_RELEASE: begin
              if (stat.id_oor || stat.used_zero || stat.fc_full) begin
                st_nxt = ST_RANGE;
              end else begin
                cm_nxt = CM_REL;
              end
            end
            OP_RESERVE: begin
              if (stat.id_oor) begin
                st_nxt = ST_RANGE;
              end else if (stat.id_ge_mark) begin
                if (stat.gap_ovf) begin
                  st_nxt = ST_RANGE;
                end else begin
                  cmd.ptr_mark = 1'b1;
                  cm_nxt       = CM_FILL;
                  state_nxt    = S_FILL;
                end
              end else if (stat.fc_zero) begin
                st_nxt = ST_TAKEN;
              end else begin
                cmd.ptr_zero = 1'b1;
                cm_nxt       = CM_SRCH;
                state_nxt    = S_SR_RD;
              end
            end
            default: begin
              st_nxt = ST_RANGE;
            end
          endcase
        end
      end
      S_FILL: begin
        // push skipped ids mark .. id-1, oldest first
        if (stat.fill_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.wr_fill = 1'b1;
        end
      end
      S_SR_RD: begin
        cmd.rd_ptr = 1'b1;
        state_nxt  = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (stat.match) begin
          state_nxt = S_SH_RD;
        end else if (stat.srch_last) begin
          cm_nxt    = CM_FAIL;
          st_nxt    = ST_TAKEN;
          state_nxt = S_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SR_RD;
        end
      end
      S_SH_RD: begin
        // close the gap: entry ptr+1 moves down to ptr
        if (stat.srch_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_ptr1 = 1'b1;
          state_nxt   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.commit   = cm_r;
          cmd.status   = st_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cm_r    <= CM_FAIL;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      cm_r    <= cm_nxt;
      st_r    <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted before the first completed");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !stat.out_free) |=> (state_r == S_DONE && !cmd.latch))
    else $error("result dropped while output register was full");

  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= S_SH_WR)
    else $error("controller in an unused state");
`endif

endmodule

>>> hw/rtl/block_id_free_list.sv
// Block-id free list: top level joining the controller and the datapath.
//
// Hands out block ids from a LIFO free list backed by a high-water mark, and
// keeps the count of ids in use. Allocate pops the newest free id or takes the
// mark; release pushes the id after checking only its range, that some id is in
// use and that the list is not full; reserve of an id at or above the mark
// pushes every skipped id in ascending order first, and reserve below the mark
// searches the free list from its oldest entry, removes the id and compacts
// the list. The free list is a single memory with one read and one write port,
// so each transaction is processed alone. Reserve at or above the mark makes
// one push per skipped id. In a reserve below the mark every stack entry is
// either read and compared or read and moved down. A result that cannot leave
// stalls the block until the output register is free. A new request is taken
// while the previous result still waits in the output register. The memory
// needs no clearing after reset; the block starts with no ids in use.
module block_id_free_list import bidfl_pkg::*; #(
  parameter int MAX_IDS = MAX_IDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bidfl_req_if.sink   in_ch,
  bidfl_rsp_if.source out_ch
);

  bidfl_cmd_t  cmd;
  bidfl_stat_t stat;
  logic        in_ready;

  bidfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  bidfl_dp #(
    .MAX_IDS (MAX_IDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_block_id      (in_ch.block_id),
    .cmd              (cmd),
    .out_ready        (out_ch.ready),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_result_id    (out_ch.result_id),
    .out_status       (out_ch.status),
    .out_in_use_count (out_ch.in_use_count)
  );

  assign in_ch.ready = in_ready;

endmodule

>>> dv/block_id_free_list_tb.sv
// Self-checking testbench for the block-id free list: directed table, then random traffic.
`timescale 1ns / 100ps

module block_id_free_list_tb;
  import bidfl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_IDS   = MAX_IDS_DEF;
  localparam int MIX_ITEMS = 100;    // mixed transactions per idling phase
  localparam int HOLD_CYC  = 300;    // long receiver hold-off
  localparam int WDOG_LIM  = 20000;  // idle cycles before the run is declared hung
  localparam int DRAIN_CYC = 16;
  localparam int DIR_N     = 22;

  typedef struct packed {
    logic [ID_W-1:0]  rid;
    bidfl_st_t        st;
    logic [USE_W-1:0] cnt;
  } rsp_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic             typed;
    logic [ID_W-1:0]  rid;
    bidfl_st_t        st;
    logic [USE_W-1:0] cnt;
  } dir_row_t;

  logic clk;
  logic rst_n;

  bidfl_req_if req ();
  bidfl_rsp_if rsp ();

  block_id_free_list #(.MAX_IDS(NUM_IDS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req),
    .out_ch (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow allocator state
  logic [ID_W-1:0] fl_stack [NUM_IDS];
  int              fl_count;
  int              hwm;
  int              busy_count;
  bit              id_busy [NUM_IDS];

  rsp_t pending_rsp [$];
  int   err_count;
  int   idle_cycles;
  int   src_idle_pct;
  int   snk_idle_pct;
  bit   hold_req;
  bit   rst_done;
  bit   exhausted_seen;

  // result fields read off directly where obvious; zero rows go to the predictor
  dir_row_t dir_tab [DIR_N] = '{
    '{OP_RELEASE, 10'd0,    1'b1, 10'd0,    ST_RANGE, 11'd0},  // nothing in use yet
    '{OP_UNUSED,  10'd1023, 1'b1, 10'd1023, ST_RANGE, 11'd0},
    '{OP_ALLOC,   10'd1023, 1'b1, 10'd0,    ST_OK,    11'd1},
    '{OP_ALLOC,   10'd0,    1'b1, 10'd1,    ST_OK,    11'd2},
    '{OP_RESERVE, 10'd1,    1'b1, 10'd1,    ST_TAKEN, 11'd2},
    '{OP_RESERVE, 10'd2,    1'b1, 10'd2,    ST_OK,    11'd3},  // exactly at the mark
    '{OP_RESERVE, 10'd6,    1'b1, 10'd6,    ST_OK,    11'd4},  // skips 3..5
    '{OP_RESERVE, 10'd4,    1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_RESERVE, 10'd4,    1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_ALLOC,   10'd0,    1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_RESERVE, 10'd3,    1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_ALLOC,   10'd0,    1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_RELEASE, 10'd1023, 1'b0, 10'd0,    ST_OK,    11'd0},  // never handed out
    '{OP_RELEASE, 10'd0,    1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_RELEASE, 10'd1023, 1'b0, 10'd0,    ST_OK,    11'd0},  // duplicate on the list
    '{OP_RESERVE, 10'd1023, 1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_ALLOC,   10'd0,    1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_ALLOC,   10'd0,    1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_RELEASE, 10'h2AA,  1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_RELEASE, 10'h155,  1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_RESERVE, 10'h155,  1'b0, 10'd0,    ST_OK,    11'd0},
    '{OP_UNUSED,  10'd0,    1'b0, 10'd0,    ST_OK,    11'd0}
  };

  function automatic void push_free(input int id);
    fl_stack[fl_count] = ID_W'(id);
    fl_count++;
  endfunction

  function automatic rsp_t predict_step(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    rsp_t r;
    int   i;
    int   hit;
    r.rid = id;
    r.st  = ST_RANGE;
    hit   = -1;
    case (op)
      OP_ALLOC: begin
        if (fl_count > 0) begin
          fl_count--;
          r.rid = fl_stack[fl_count];
          r.st  = ST_OK;
        end else if (hwm < NUM_IDS) begin
          r.rid = ID_W'(hwm);
          hwm++;
          r.st = ST_OK;
        end else begin
          r.rid = '0;
          exhausted_seen = 1'b1;
        end
        if (r.st == ST_OK) begin
          busy_count++;
          id_busy[r.rid] = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (int'(id) < NUM_IDS && busy_count != 0 && fl_count < NUM_IDS) begin
          push_free(int'(id));
          busy_count--;
          id_busy[id] = 1'b0;
          r.st = ST_OK;
        end
      end
      OP_RESERVE: begin
        if (int'(id) >= NUM_IDS) begin
          r.st = ST_RANGE;
        end else if (int'(id) >= hwm) begin
          if (fl_count + int'(id) - hwm <= NUM_IDS) begin
            for (i = hwm; i < int'(id); i++) push_free(i);
            hwm = int'(id) + 1;
            busy_count++;
            id_busy[id] = 1'b1;
            r.st = ST_OK;
          end
        end else begin
          // oldest match wins; the rest of the list slides down in order
          for (i = 0; i < fl_count; i++)
            if (hit < 0 && fl_stack[i] == id) hit = i;
          if (hit >= 0) begin
            for (i = hit; i + 1 < fl_count; i++) fl_stack[i] = fl_stack[i + 1];
            fl_count--;
            busy_count++;
            id_busy[id] = 1'b1;
            r.st = ST_OK;
          end else begin
            r.st = ST_TAKEN;
          end
        end
      end
      default: r.st = ST_RANGE;
    endcase
    r.cnt = USE_W'(busy_count);
    return r;
  endfunction

  // probe for an id that is currently handed out
  function automatic logic [ID_W-1:0] pick_busy_id();
    int k;
    int c;
    if (hwm > 0)
      for (k = 0; k < 16; k++) begin
        c = $urandom_range(hwm - 1);
        if (id_busy[c]) return ID_W'(c);
      end
    return ID_W'($urandom);
  endfunction

  task automatic pick_request(output logic [OP_W-1:0] op, output logic [ID_W-1:0] id);
    int r;
    int gap;
    r  = $urandom_range(99);
    op = OP_ALLOC;
    id = ID_W'($urandom);
    if (fl_count > 40) begin
      // long free list makes searches slow: drain it
      if (r >= 85) begin
        op = OP_RELEASE;
        id = pick_busy_id();
      end
    end else if (r < 40) begin
      op = OP_ALLOC;
    end else if (r < 55) begin
      op = OP_RELEASE;
      id = pick_busy_id();
    end else if (r < 67) begin
      op = OP_RESERVE;
      if (fl_count > 0) id = fl_stack[$urandom_range(fl_count - 1)];
    end else if (r < 79) begin
      op = OP_RESERVE;
      if (hwm < NUM_IDS) begin
        gap = $urandom_range(15);
        if (hwm + gap > NUM_IDS - 1) gap = NUM_IDS - 1 - hwm;
        id = ID_W'(hwm + gap);
      end else if (fl_count > 0) begin
        id = fl_stack[$urandom_range(fl_count - 1)];
      end
    end else if (r < 85) begin
      op = OP_RESERVE;
      id = pick_busy_id();
    end else begin
      op = OP_W'($urandom_range(3));
      if (op == OP_RESERVE && $urandom_range(19) != 0) begin
        id = ID_W'($urandom_range((hwm + 2 < NUM_IDS) ? hwm + 2 : NUM_IDS - 1));
      end
    end
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input bit typed, input rsp_t typed_rsp);
    rsp_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.block_id  <= id;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pred = predict_step(op, id);
    pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : pred);
  endtask

  task automatic pause_until_drained();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic run_mix(input int n);
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    int              k;
    for (k = 0; k < n; k++) begin
      pick_request(op, id);
      send_item(op, id, 1'b0, '0);
    end
  endtask

  // sender
  initial begin
    rsp_t trsp;
    int   k;
    rst_n          = 1'b0;
    rst_done       = 1'b0;
    hold_req       = 1'b0;
    exhausted_seen = 1'b0;
    err_count      = 0;
    fl_count       = 0;
    hwm            = 0;
    busy_count     = 0;
    src_idle_pct   = 16;
    snk_idle_pct   = 64;
    for (k = 0; k < NUM_IDS; k++) begin
      fl_stack[k] = '0;
      id_busy[k]  = 1'b0;
    end
    req.valid     <= 1'b0;
    req.operation <= OP_ALLOC;
    req.block_id  <= '0;
    repeat (4) @(posedge clk);
    rst_n    <= 1'b1;
    @(posedge clk);
    rst_done = 1'b1;

    for (k = 0; k < DIR_N; k++) begin
      trsp.rid = dir_tab[k].rid;
      trsp.st  = dir_tab[k].st;
      trsp.cnt = dir_tab[k].cnt;
      send_item(dir_tab[k].op, dir_tab[k].id, dir_tab[k].typed, trsp);
    end
    run_mix(MIX_ITEMS);
    pause_until_drained();

    src_idle_pct = 64;
    snk_idle_pct = 16;
    run_mix(MIX_ITEMS);
    pause_until_drained();

    // no idling; fill the id space until allocation runs dry, under a long hold-off
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = 1'b1;
    for (k = 0; k < 2 * NUM_IDS && !exhausted_seen; k++)
      send_item(OP_ALLOC, ID_W'($urandom), 1'b0, '0);
    send_item(OP_ALLOC, '0, 1'b0, '0);
    run_mix(MIX_ITEMS);
    pause_until_drained();

    repeat (DRAIN_CYC) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        rsp.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end else begin
        rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
        @(posedge clk);
      end
    end
  end

  // response check and watchdog
  always @(posedge clk) begin
    rsp_t want;
    if (rst_done) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected transaction: id %0d status %0d count %0d",
                     rsp.result_id, rsp.status, rsp.in_use_count);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.result_id !== want.rid || rsp.status !== want.st ||
              rsp.in_use_count !== want.cnt) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: id %0d/%0d status %0d/%0d count %0d/%0d (exp/got)",
                       want.rid, rsp.result_id, want.st, rsp.status,
                       want.cnt, rsp.in_use_count);
          end
        end
      end
      if (idle_cycles >= WDOG_LIM) begin
        $display("TB_ERROR");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule
